/* hw/rtl/integer_matrix_determinant_defines.svh */
// assertion macros shared by the checker of the determinant block
// needs a clock named clock and a reset named reset in the scope of use
`ifndef INTEGER_MATRIX_DETERMINANT_DEFINES_SVH
`define INTEGER_MATRIX_DETERMINANT_DEFINES_SVH

// checked only outside reset
`define IMD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define IMD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/imd_pkg.sv */
// shared constants and types of the integer matrix determinant block
// no dependencies
package imd_pkg;

   localparam int ORDER_W       = 3;
   localparam int ELEM_W        = 16;
   localparam int LIMB_W        = 16;
   localparam int DET_W         = 64;
   localparam int DEF_MAX_ORDER = 4;
   localparam int PADDR_W       = 3;
   localparam int PDATA_W       = 32;

   localparam logic REG_ORDER = 1'b0;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;

   localparam logic [DET_W-1:0] DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
   localparam logic [DET_W-1:0] DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

   typedef struct packed {
      logic shift;
      logic init;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic step;
   } mac_ctl_type;

endpackage

/* hw/rtl/imd_limb_cell.sv */
// one limb of the running product ring, shifts towards the head each step
// depends on imd_pkg
module imd_limb_cell #(
   parameter logic [imd_pkg::LIMB_W-1:0] INIT_VALUE = '0
) (
   input  logic                        clock,
   input  imd_pkg::cell_ctl_type       ctl,
   input  logic [imd_pkg::LIMB_W-1:0]  shift_in,
   output logic [imd_pkg::LIMB_W-1:0]  limb
);

   logic [imd_pkg::LIMB_W-1:0] limb_ff;
   logic [imd_pkg::LIMB_W-1:0] limb_in;

   always_comb begin
      limb_in = limb_ff;
      if (ctl.init) begin
         limb_in = INIT_VALUE;
      end else if (ctl.shift) begin
         limb_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      limb_ff <= limb_in;
   end

   assign limb = limb_ff;

endmodule

/* hw/rtl/imd_mac.sv */
// limb multiplier at the head of the ring, carry held between beats
// depends on imd_pkg
module imd_mac (
   input  logic                        clock,
   input  imd_pkg::mac_ctl_type        ctl,
   input  logic [imd_pkg::LIMB_W-1:0]  limb_in,
   input  logic [imd_pkg::LIMB_W-1:0]  mag,
   output logic [imd_pkg::LIMB_W-1:0]  limb_out
);

   localparam int PW = 2 * imd_pkg::LIMB_W;

   logic [imd_pkg::LIMB_W-1:0] carry_ff;
   logic [imd_pkg::LIMB_W-1:0] carry_in;
   logic [PW-1:0]              prod;

   // limb * mag + carry never exceeds 2^32 - 1
   assign prod = PW'(limb_in) * PW'(mag) + PW'(carry_ff);
   assign limb_out = prod[imd_pkg::LIMB_W-1:0];

   always_comb begin
      carry_in = carry_ff;
      if (ctl.clear) begin
         carry_in = '0;
      end else if (ctl.step) begin
         carry_in = prod[PW-1:imd_pkg::LIMB_W];
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

endmodule

/* hw/rtl/integer_matrix_determinant.sv */
// determinant of an n x n signed matrix, n = order (1..MAX_ORDER), loaded row-major
// elements are taken one per cycle while the block is in its load state; the result
// is set by the limb ring that multiplies each permutation product one 16-bit limb
// per cycle; a stalled result holds back only the finish step, the next matrix may
// load meanwhile
// synchronous active-high reset: order 1, count zero, no result pending
module integer_matrix_determinant #(
   parameter int MAX_ORDER = imd_pkg::DEF_MAX_ORDER
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [imd_pkg::ELEM_W-1:0]   req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [imd_pkg::DET_W-1:0]    rsp_determinant,
   output logic                                rsp_overflow,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [imd_pkg::PADDR_W-1:0]         paddr,
   input  logic [imd_pkg::PDATA_W-1:0]         pwdata,
   output logic [imd_pkg::PDATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int OW    = imd_pkg::ORDER_W;
   localparam int LW    = imd_pkg::LIMB_W;
   localparam int EW    = imd_pkg::ELEM_W;
   localparam int DW    = imd_pkg::DET_W;
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NLIMB = MAX_ORDER;
   localparam int RW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ACC_W = LW * (MAX_ORDER + 1);
   localparam int XW    = (ACC_W > DW) ? ACC_W : DW;

   typedef enum logic [2:0] {
      ST_LOAD, ST_START, ST_FETCH, ST_MUL, ST_NEXT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [OW-1:0]  order_ff, order_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [OW-1:0]  digit_ff [MAX_ORDER];
   logic [OW-1:0]  digit_in [MAX_ORDER];
   logic [RW-1:0]  row_ff, row_in;
   logic [RW-1:0]  k_ff, k_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [MAX_ORDER-1:0] used_ff, used_in;
   logic           negpar_ff, negpar_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic           add_en_ff, add_en_in;
   logic [LW-1:0]  add_limb_ff, add_limb_in;
   logic [RW-1:0]  add_pos_ff, add_pos_in;
   logic           add_neg_ff, add_neg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]  det_ff, det_in;
   logic           ovf_ff, ovf_in;

   logic [EW-1:0]  mem [DEPTH];
   logic [EW-1:0]  rd_ff;
   logic           wr_en;
   logic [AW-1:0]  rd_addr;
   logic           rd_en;

   logic [OW-1:0]  n;
   logic [CW-1:0]  nsq;
   logic           req_accept;
   logic           csr_write;
   logic           last_row;
   logic           last_limb;
   logic [RW-1:0]  col;
   logic [OW-1:0]  col_cnt;
   logic           col_found;
   logic           parity;
   logic           wrap;
   logic           carry;
   logic [LW-1:0]  mag;
   logic [ACC_W-1:0] addend;
   logic signed [XW-1:0] accx;
   logic [XW-DW:0] acc_top;
   logic           fits;

   logic [LW-1:0]  limb [NLIMB];
   logic [LW-1:0]  mac_out;
   imd_pkg::cell_ctl_type cell_ctl;
   imd_pkg::mac_ctl_type  mac_ctl;

   assign n = (order_ff == '0) ? OW'(1)
            : ((order_ff > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : order_ff);
   assign nsq = CW'(n) * CW'(n);
   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid & ~req_stall;
   assign csr_write  = psel & penable & pwrite;
   assign last_row   = (OW'(row_ff) == n - OW'(1));
   assign last_limb  = (k_ff == RW'(NLIMB - 1));
   assign mag = rd_ff[EW-1] ? LW'(~rd_ff + EW'(1)) : LW'(rd_ff);

   // c-th free column, c being this row's lehmer digit
   always_comb begin
      col = '0;
      col_cnt = '0;
      col_found = 1'b0;
      for (int j = 0; j < MAX_ORDER; j++) begin
         if (!used_ff[j] && !col_found) begin
            if (col_cnt == digit_ff[row_ff]) begin
               col = RW'(j);
               col_found = 1'b1;
            end else begin
               col_cnt = col_cnt + OW'(1);
            end
         end
      end
   end

   // inversion count of the permutation is the digit sum
   always_comb begin
      parity = 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         parity = parity ^ digit_ff[i][0];
      end
   end

   assign addend = ACC_W'(add_limb_ff) << (LW * add_pos_ff);
   assign accx = XW'(acc_ff);
   assign acc_top = accx[XW-1:DW-1];
   assign fits = (&acc_top) | ~(|acc_top);

   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      count_in     = count_ff;
      digit_in     = digit_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      used_in      = used_ff;
      negpar_in    = negpar_ff;
      acc_in       = acc_ff;
      add_en_in    = 1'b0;
      add_limb_in  = mac_out;
      add_pos_in   = k_ff;
      add_neg_in   = parity ^ negpar_ff ^ rd_ff[EW-1];
      rsp_valid_in = rsp_valid_ff;
      det_in       = det_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = base_ff + AW'(col);
      cell_ctl     = '0;
      mac_ctl      = '0;
      wrap         = 1'b0;
      carry        = 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (add_en_ff) begin
         acc_in = add_neg_ff ? acc_ff - signed'(addend) : acc_ff + signed'(addend);
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               wr_en = 1'b1;
               if (count_ff + CW'(1) == nsq) begin
                  count_in = '0;
                  acc_in   = '0;
                  for (int i = 0; i < MAX_ORDER; i++) begin
                     digit_in[i] = '0;
                  end
                  state_in = ST_START;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_START: begin
            row_in    = '0;
            base_in   = '0;
            used_in   = '0;
            negpar_in = 1'b0;
            cell_ctl.init = 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            rd_en = 1'b1;
            used_in[col] = 1'b1;
            mac_ctl.clear = 1'b1;
            k_in = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cell_ctl.shift = 1'b1;
            mac_ctl.step   = 1'b1;
            add_en_in      = last_row;
            if (last_limb) begin
               negpar_in = negpar_ff ^ rd_ff[EW-1];
               if (last_row) begin
                  state_in = ST_NEXT;
               end else begin
                  row_in   = row_ff + RW'(1);
                  base_in  = base_ff + AW'(n);
                  state_in = ST_FETCH;
               end
            end else begin
               k_in = k_ff + RW'(1);
            end
         end
         ST_NEXT: begin
            for (int i = MAX_ORDER - 1; i >= 0; i--) begin
               if ((OW'(i) < n - OW'(1)) && carry) begin
                  if (digit_ff[i] == n - OW'(1) - OW'(i)) begin
                     digit_in[i] = '0;
                  end else begin
                     digit_in[i] = digit_ff[i] + OW'(1);
                     carry = 1'b0;
                  end
               end
            end
            wrap = carry;
            state_in = wrap ? ST_FINISH : ST_START;
         end
         ST_FINISH: begin
            // wait here while the previous result beat is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               det_in = fits ? accx[DW-1:0]
                      : (accx[XW-1] ? imd_pkg::DET_MIN : imd_pkg::DET_MAX);
               ovf_in = ~fits;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_write && paddr[2] == imd_pkg::REG_ORDER) begin
         order_in = pwdata[OW-1:0];
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         order_ff     <= imd_pkg::ORDER_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         add_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         add_en_ff    <= add_en_in;
      end
      digit_ff    <= digit_in;
      row_ff      <= row_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      used_ff     <= used_in;
      negpar_ff   <= negpar_in;
      acc_ff      <= acc_in;
      add_limb_ff <= add_limb_in;
      add_pos_ff  <= add_pos_in;
      add_neg_ff  <= add_neg_in;
      det_ff      <= det_in;
      ovf_ff      <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_element;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // product ring: limb 0 feeds the multiplier, the new limb enters at the tail
   for (genvar g = 0; g < NLIMB; g++) begin : g_cell
      logic [LW-1:0] shift_src;
      if (g == NLIMB - 1) begin : g_tail
         assign shift_src = mac_out;
      end else begin : g_body
         assign shift_src = limb[g+1];
      end
      imd_limb_cell #(
         .INIT_VALUE((g == 0) ? LW'(1) : LW'(0))
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .shift_in (shift_src),
         .limb     (limb[g])
      );
   end

   imd_mac u_mac (
      .clock    (clock),
      .ctl      (mac_ctl),
      .limb_in  (limb[0]),
      .mag      (mag),
      .limb_out (mac_out)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = det_ff;
   assign rsp_overflow    = ovf_ff;
   assign prdata          = imd_pkg::PDATA_W'(order_ff);
   assign pready          = 1'b1;

endmodule

/* hw/rtl/imd_checker.sv */
// port-level checks of the determinant block, bound to its top level
// depends on imd_pkg and integer_matrix_determinant_defines.svh
`include "integer_matrix_determinant_defines.svh"

module imd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [imd_pkg::DET_W-1:0]  rsp_determinant,
   input logic                              rsp_overflow
);

   `IMD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result beat after reset")
   `IMD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_determinant) && $stable(rsp_overflow), "stalled result beat changed")
   `IMD_ASSERT(a_sat_value, rsp_valid && rsp_overflow |-> rsp_determinant == imd_pkg::DET_MAX || rsp_determinant == imd_pkg::DET_MIN, "overflow without saturated value")
   `IMD_ASSERT(a_stall_known, !$isunknown(req_stall), "element stall unknown")

endmodule

bind integer_matrix_determinant imd_checker u_imd_checker (.*);
